FILE: rtl/ist_pkg.sv
// ist_pkg: shared constants for the id set table
`timescale 1ns / 1ps

package ist_pkg;

    // default number of slots in the store
    localparam int CAPACITY_DEF = 16;

    // field widths fixed by the interface
    localparam int ID_W     = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

FILE: rtl/ist_mem.sv
// ist_mem: single write port, single registered read port entry store
`timescale 1ns / 1ps

module ist_mem #(
    parameter int DEPTH = ist_pkg::CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [ist_pkg::ID_W-1:0] wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [ist_pkg::ID_W-1:0] rd_data
);

    logic [ist_pkg::ID_W-1:0] mem_q [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem_q[rd_addr];
    end

endmodule

FILE: rtl/id_set_table.sv
// id_set_table: unordered id set with append, swap-remove delete and lookup
// flow: accept, then scan the store one entry per cycle through the registered read port
//   until the first match or the end, then apply the op; a hit delete then reads the last entry
//   and moves it into the freed slot; the result is registered once the result side can take it
// accept: a new word is taken only after the result of the last one has been loaded
// reset: aresetn synchronous, active low; clears the entry count and handshakes
`timescale 1ns / 1ps

module id_set_table #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ist_pkg::FUNC_W-1:0]  s_func,
    input  logic [ist_pkg::ID_W-1:0]    s_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ist_pkg::STATUS_W-1:0] m_status,
    output logic                        m_found,
    output logic [ist_pkg::POS_W-1:0]   m_position,
    output logic [ist_pkg::CNT_W-1:0]   m_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_OP   = 3'd2;
    localparam logic [2:0] ST_MVRD = 3'd3;
    localparam logic [2:0] ST_MVWR = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_idx_reg, issue_idx_next;
    logic cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic hit_reg, hit_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [ist_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ist_pkg::FUNC_W-1:0] func_reg;
    logic [ist_pkg::ID_W-1:0] key_reg;

    logic m_valid_reg, m_valid_next;
    logic [ist_pkg::STATUS_W-1:0] m_status_reg;
    logic m_found_reg;
    logic [ist_pkg::POS_W-1:0] m_position_reg;
    logic [ist_pkg::CNT_W-1:0] m_count_reg;

    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [ist_pkg::ID_W-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [ist_pkg::ID_W-1:0] rd_data;

    logic s_take, out_load, issue;
    logic [CW-1:0] last_idx;
    logic [IW+ist_pkg::POS_W-1:0] slot_wide;
    logic [CW+ist_pkg::CNT_W-1:0] count_wide;

    ist_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_take   = s_valid && s_ready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign issue    = (state_reg == ST_SCAN) && !hit_reg && (issue_idx_reg < count_reg);
    assign last_idx = count_reg - CW'(1);

    assign slot_wide  = {{ist_pkg::POS_W{1'b0}}, slot_reg};
    assign count_wide = {{ist_pkg::CNT_W{1'b0}}, count_reg};

    // read port: scan address, or the last slot for the swap on delete
    always_comb begin
        if (state_reg == ST_MVRD) begin
            rd_addr = last_idx[IW-1:0];
        end else begin
            rd_addr = issue_idx_reg[IW-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = key_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    issue_idx_next = '0;
                    hit_next       = 1'b0;
                    slot_next      = '0;
                    status_next    = ist_pkg::STATUS_OK;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one read issued and one compare done per cycle
                if (issue) begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg[IW-1:0];
                end
                if (cmp_valid_reg && !hit_reg && (rd_data == key_reg)) begin
                    hit_next  = 1'b1;
                    slot_next = cmp_idx_reg;
                end
                if (!issue && !cmp_valid_reg) begin
                    state_next = ST_OP;
                end
            end
            ST_OP: begin
                case (func_reg)
                    ist_pkg::FUNC_ADD: begin
                        if (count_reg >= CW'(CAPACITY)) begin
                            status_next = ist_pkg::STATUS_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IW-1:0];
                            slot_next  = count_reg[IW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_FIN;
                    end
                    ist_pkg::FUNC_DEL: begin
                        if (!hit_reg) begin
                            status_next = ist_pkg::STATUS_NOT_FOUND;
                            state_next  = ST_FIN;
                        end else begin
                            state_next = ST_MVRD;
                        end
                    end
                    default: begin
                        // query, and the unused code acts as a query
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MVRD: begin
                state_next = ST_MVWR;
            end
            ST_MVWR: begin
                // last entry moves into the freed slot
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = rd_data;
                count_next = last_idx;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_reg       <= hit_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        if (s_take) begin
            func_reg <= s_func;
            key_reg  <= s_id;
        end
        if (out_load) begin
            m_status_reg   <= status_reg;
            m_found_reg    <= hit_reg;
            m_position_reg <= slot_wide[ist_pkg::POS_W-1:0];
            m_count_reg    <= count_wide[ist_pkg::CNT_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;
    assign m_count    = m_count_reg;

endmodule
